// File: rtl/cbfq_pkg.sv
// Package for the cost-budgeted FIFO command queue.
// Holds the request, result and entry types, the result and opcode codes and
// the controller state type. It depends on nothing else.
package cbfq_pkg;

   // Default queue depth and the fixed width of the count fields.
   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int COUNT_W         = 6;

   // A cost budget of all ones means the budget is unlimited.
   localparam logic [63:0] COST_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // Request opcodes.
   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DRAIN   = 2'd1,
      OP_CLOSE   = 2'd2
   } op_type;

   // Result kinds.
   typedef enum logic [2:0] {
      KIND_ACCEPTED    = 3'd0,
      KIND_NULL_REJ    = 3'd1,
      KIND_CLOSED_REJ  = 3'd2,
      KIND_FULL        = 3'd3,
      KIND_RUN         = 3'd4,
      KIND_DRAIN_EMPTY = 3'd5,
      KIND_CANCEL      = 3'd6,
      KIND_CLOSE_DONE  = 3'd7
   } kind_type;

   // One request on the input channel.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] callback_handle;
      logic [31:0] payload_word;
      logic [63:0] entry_cost;
      logic [31:0] cancel_handle;
      logic [7:0]  run_limit;
      logic [63:0] cost_budget;
   } req_type;

   // One result on the output channel.
   typedef struct packed {
      kind_type             result_kind;
      logic [31:0]          out_handle;
      logic [31:0]          out_payload;
      logic [63:0]          out_cost;
      logic                 is_last;
      logic [COUNT_W-1:0]   run_count;
      logic [COUNT_W-1:0]   pending_count;
      logic [31:0]          submitted_total;
      logic [31:0]          drained_total;
   } rsp_type;

   // One queue entry as it is kept in the entry memory.
   typedef struct packed {
      logic [31:0] callback;
      logic [31:0] payload;
      logic [63:0] cost;
      logic [31:0] cancel;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ,
      ST_DRAIN_RD,
      ST_DRAIN_EVAL,
      ST_DRAIN_FIN,
      ST_FLUSH_RD,
      ST_FLUSH_EVAL,
      ST_CLOSE_FIN
   } state_type;

endpackage

// File: rtl/cbfq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Takes its default sizes from cbfq_pkg; the contents have no reset.
module cbfq_ram #(
   parameter int WIDTH = cbfq_pkg::ENTRY_W,
   parameter int DEPTH = cbfq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds between reads.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cost_budgeted_fifo_queue_unit.sv
// Top level of the cost-budgeted FIFO command queue.
// Uses cbfq_pkg for its types and codes and cbfq_ram for the entry memory.
//
// The queue keeps up to QUEUE_DEPTH commands (2 to 63) in one entry memory
// with a registered read; head, tail, occupancy, the closed flag and the two
// wrapping totals sit in flip-flops. One request is worked on at a time and
// req_ready is high only while the controller is idle; a finished result sits
// in an output register, so a new request can be taken while it waits. An
// enqueue is taken in ST_IDLE and then checked and written in ST_ENQ. A drain
// or a close is taken in ST_IDLE, then needs a memory read and an evaluation
// for each entry it removes, then a check that finds the queue empty (or, for
// a drain, the item limit reached) and a state that gives the final result. A
// drain that the budget stops also reads and evaluates the entry it refuses.
// The registered memory read is why each entry needs a read and an evaluation.
// Each run result is held back one entry so that the last one can carry
// is_last. A stall on the result channel can hold the controller in a state
// that has a result to send. The memory needs no clearing after reset; only
// occupied entries are ever read.
module cost_budgeted_fifo_queue_unit #(
   parameter int QUEUE_DEPTH = cbfq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbfq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbfq_pkg::rsp_type rsp_data
);

   import cbfq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   // Controller and queue state.
   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [COUNT_W-1:0] occ_ff, occ_in;
   logic               closed_ff, closed_in;
   logic [31:0]        sub_ff, sub_in;
   logic [31:0]        drn_ff, drn_in;
   logic [COUNT_W-1:0] runs_ff, runs_in;
   logic [63:0]        spent_ff, spent_in;
   rsp_type            hold_ff, hold_in;
   logic               hold_valid_ff, hold_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Memory port signals.
   logic               ram_wr_en;
   entry_type          ram_wr_data;
   logic               ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_bits;
   entry_type          ent;

   // Budget arithmetic for the entry at the head.
   logic [64:0] sum_wide;
   logic [63:0] sum_sat;
   logic        budget_stop;
   logic        slot_free;
   logic        limit_hit;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      nxt = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
      return nxt;
   endfunction

   function automatic rsp_type make_rsp(
      input kind_type           kind,
      input logic [31:0]        handle,
      input logic [31:0]        payload,
      input logic [63:0]        cost,
      input logic               last,
      input logic [COUNT_W-1:0] runs,
      input logic [COUNT_W-1:0] pend,
      input logic [31:0]        sub,
      input logic [31:0]        drn
   );
      rsp_type r;
      r.result_kind     = kind;
      r.out_handle      = handle;
      r.out_payload     = payload;
      r.out_cost        = cost;
      r.is_last         = last;
      r.run_count       = runs;
      r.pending_count   = pend;
      r.submitted_total = sub;
      r.drained_total   = drn;
      return r;
   endfunction

   // Entry memory, written at the tail and read at the head.
   cbfq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_bits)
   );

   assign ent = entry_type'(ram_rd_bits);

   assign ram_wr_data.callback = req_ff.callback_handle;
   assign ram_wr_data.payload  = req_ff.payload_word;
   assign ram_wr_data.cost     = req_ff.entry_cost;
   assign ram_wr_data.cancel   = req_ff.cancel_handle;

   // Saturating running cost and the budget stop rule for the head entry.
   assign sum_wide = {1'b0, spent_ff} + {1'b0, ent.cost};
   assign sum_sat  = sum_wide[64] ? COST_ALL_ONES : sum_wide[63:0];
   assign budget_stop = (req_ff.cost_budget != COST_ALL_ONES) && (ent.cost != '0) &&
                        (sum_sat > req_ff.cost_budget) &&
                        ((runs_ff != '0) || (req_ff.cost_budget == '0));

   assign limit_hit = (req_ff.run_limit != '0) && ({2'b00, runs_ff} >= req_ff.run_limit);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // State and data registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         occ_ff        <= '0;
         closed_ff     <= 1'b0;
         sub_ff        <= '0;
         drn_ff        <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         occ_ff        <= occ_in;
         closed_ff     <= closed_in;
         sub_ff        <= sub_in;
         drn_ff        <= drn_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      runs_ff  <= runs_in;
      spent_ff <= spent_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

   // Next state, queue updates and result generation.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      closed_in     = closed_ff;
      sub_in        = sub_ff;
      drn_in        = drn_ff;
      runs_in       = runs_ff;
      spent_in      = spent_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      req_ready     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               case (req_data.opcode)
                  OP_ENQUEUE: begin
                     state_in = ST_ENQ;
                  end
                  OP_DRAIN: begin
                     runs_in  = '0;
                     spent_in = '0;
                     state_in = ST_DRAIN_RD;
                  end
                  OP_CLOSE: begin
                     closed_in = 1'b1;
                     state_in  = ST_FLUSH_RD;
                  end
                  default: begin
                     // The unused opcode is dropped without a result.
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_ENQ: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (req_ff.callback_handle == '0) begin
                  rsp_in = make_rsp(KIND_NULL_REJ, '0, '0, '0, 1'b1, '0, occ_ff,
                                    sub_ff, drn_ff);
               end else if (closed_ff) begin
                  rsp_in = make_rsp(KIND_CLOSED_REJ, '0, '0, '0, 1'b1, '0, occ_ff,
                                    sub_ff, drn_ff);
               end else if (occ_ff >= COUNT_W'(QUEUE_DEPTH)) begin
                  rsp_in = make_rsp(KIND_FULL, '0, '0, '0, 1'b1, '0, occ_ff,
                                    sub_ff, drn_ff);
               end else begin
                  ram_wr_en = 1'b1;
                  tail_in   = next_slot(tail_ff);
                  occ_in    = occ_ff + 1'b1;
                  sub_in    = sub_ff + 1'b1;
                  rsp_in    = make_rsp(KIND_ACCEPTED, '0, '0, '0, 1'b1, '0, occ_in,
                                       sub_in, drn_ff);
               end
               state_in = ST_IDLE;
            end
         end

         ST_DRAIN_RD: begin
            if ((occ_ff == '0) || limit_hit) begin
               state_in = ST_DRAIN_FIN;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_DRAIN_EVAL;
            end
         end

         ST_DRAIN_EVAL: begin
            if (budget_stop) begin
               state_in = ST_DRAIN_FIN;
            end else if (!hold_valid_ff || slot_free) begin
               // The held run result is not the last one: send it on.
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = hold_ff;
               end
               head_in       = next_slot(head_ff);
               occ_in        = occ_ff - 1'b1;
               runs_in       = runs_ff + 1'b1;
               drn_in        = drn_ff + 1'b1;
               spent_in      = sum_sat;
               hold_valid_in = 1'b1;
               hold_in       = make_rsp(KIND_RUN, ent.callback, ent.payload, ent.cost,
                                        1'b0, runs_in, occ_in, sub_ff, drn_in);
               state_in      = ST_DRAIN_RD;
            end
         end

         ST_DRAIN_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (hold_valid_ff) begin
                  rsp_in         = hold_ff;
                  rsp_in.is_last = 1'b1;
               end else begin
                  rsp_in = make_rsp(KIND_DRAIN_EMPTY, '0, '0, '0, 1'b1, '0, occ_ff,
                                    sub_ff, drn_ff);
               end
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_FLUSH_RD: begin
            if (occ_ff == '0) begin
               state_in = ST_CLOSE_FIN;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_FLUSH_EVAL;
            end
         end

         ST_FLUSH_EVAL: begin
            // Entries without a cancel handle leave silently.
            if (ent.cancel == '0) begin
               head_in  = next_slot(head_ff);
               occ_in   = occ_ff - 1'b1;
               state_in = ST_FLUSH_RD;
            end else if (slot_free) begin
               head_in      = next_slot(head_ff);
               occ_in       = occ_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(KIND_CANCEL, ent.cancel, ent.payload, '0, 1'b0,
                                       '0, occ_in, sub_ff, drn_ff);
               state_in     = ST_FLUSH_RD;
            end
         end

         ST_CLOSE_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(KIND_CLOSE_DONE, '0, '0, '0, 1'b1, '0, occ_ff,
                                       sub_ff, drn_ff);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // The occupancy never goes beyond the depth of the queue.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy exceeds the queue depth");

   // Tail always sits occupancy entries past head, modulo the depth.
   a_ring_consistent: assert property (@(posedge clock) disable iff (reset)
      (({1'b0, COUNT_W'(head_ff)} + {1'b0, occ_ff}) >= (COUNT_W + 1)'(QUEUE_DEPTH)) ?
      ((COUNT_W + 1)'(tail_ff) == ({1'b0, COUNT_W'(head_ff)} + {1'b0, occ_ff} -
                                   (COUNT_W + 1)'(QUEUE_DEPTH))) :
      ((COUNT_W + 1)'(tail_ff) == ({1'b0, COUNT_W'(head_ff)} + {1'b0, occ_ff})))
      else $error("head, tail and occupancy disagree");

   // A closed queue never writes a new entry.
   a_no_write_closed: assert property (@(posedge clock) disable iff (reset)
      closed_ff |-> !ram_wr_en)
      else $error("entry written into a closed queue");

   // No held run result is left behind when a new request can be taken.
   a_hold_flushed: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !hold_valid_ff)
      else $error("held run result pending while idle");
`endif

endmodule

// File: tb/cbfq_dispatch_checker.sv
// Result checker for the cost-budgeted FIFO command queue testbench.
// Watches both channels, predicts every result from the accepted requests and
// compares them in order. Depends on cbfq_pkg for the request and result types.
`timescale 1ns / 1ps

module cbfq_dispatch_checker #(
   parameter int QUEUE_DEPTH = cbfq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  cbfq_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  cbfq_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                outstanding_count,
   output int                checked_count
);

   import cbfq_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // Shadow copy of the queue contents and counters.
   entry_type   entry_mem [QUEUE_DEPTH];
   int          head_slot;
   int          tail_slot;
   int          occupancy;
   bit          queue_closed;
   logic [31:0] submitted_total;
   logic [31:0] drained_total;

   // Results predicted but not yet seen, oldest first.
   rsp_type     expected_results [$];

   function automatic int next_slot(input int slot);
      return (slot + 1 >= QUEUE_DEPTH) ? 0 : slot + 1;
   endfunction

   // Cost sum that sticks at all ones instead of wrapping.
   function automatic logic [63:0] add_saturating(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[64] ? COST_ALL_ONES : sum[63:0];
   endfunction

   // Queue one expected result; the counters are taken as they stand now.
   function automatic void note_result(input kind_type kind, input logic [31:0] handle,
                                       input logic [31:0] payload, input logic [63:0] cost,
                                       input int runs);
      rsp_type outcome;
      outcome.result_kind     = kind;
      outcome.out_handle      = handle;
      outcome.out_payload     = payload;
      outcome.out_cost        = cost;
      outcome.is_last         = 1'b0;
      outcome.run_count       = COUNT_W'(runs);
      outcome.pending_count   = COUNT_W'(occupancy);
      outcome.submitted_total = submitted_total;
      outcome.drained_total   = drained_total;
      expected_results.push_back(outcome);
   endfunction

   function automatic string describe(input rsp_type r);
      return $sformatf({"kind=%0d handle=%h payload=%h cost=%h last=%0b runs=%0d",
                        " pending=%0d submitted=%0d drained=%0d"},
                       r.result_kind, r.out_handle, r.out_payload, r.out_cost, r.is_last,
                       r.run_count, r.pending_count, r.submitted_total, r.drained_total);
   endfunction

   // Work out every result that one accepted request causes.
   task automatic predict_request(input req_type r);
      entry_type   head_entry;
      rsp_type     last_result;
      logic [63:0] spent;
      int          runs;
      int          produced;
      bit          unlimited;
      produced = 0;
      if (r.opcode == OP_ENQUEUE) begin
         // A null callback wins over a closed queue, which wins over a full one.
         if (r.callback_handle == '0) begin
            note_result(KIND_NULL_REJ, '0, '0, '0, 0);
         end else if (queue_closed) begin
            note_result(KIND_CLOSED_REJ, '0, '0, '0, 0);
         end else if (occupancy >= QUEUE_DEPTH) begin
            note_result(KIND_FULL, '0, '0, '0, 0);
         end else begin
            entry_mem[tail_slot].callback = r.callback_handle;
            entry_mem[tail_slot].payload  = r.payload_word;
            entry_mem[tail_slot].cost     = r.entry_cost;
            entry_mem[tail_slot].cancel   = r.cancel_handle;
            tail_slot = next_slot(tail_slot);
            occupancy++;
            submitted_total++;
            note_result(KIND_ACCEPTED, '0, '0, '0, 0);
         end
         produced = 1;
      end else if (r.opcode == OP_DRAIN) begin
         unlimited = (r.cost_budget == COST_ALL_ONES);
         spent = '0;
         runs  = 0;
         while ((r.run_limit == 0 || runs < r.run_limit) && occupancy > 0) begin
            head_entry = entry_mem[head_slot];
            // The first entry runs anyway unless the budget is zero and it has a cost.
            if (!unlimited && head_entry.cost != '0 &&
                add_saturating(spent, head_entry.cost) > r.cost_budget &&
                (runs > 0 || r.cost_budget == '0))
               break;
            head_slot = next_slot(head_slot);
            occupancy--;
            runs++;
            drained_total++;
            spent = add_saturating(spent, head_entry.cost);
            note_result(KIND_RUN, head_entry.callback, head_entry.payload, head_entry.cost, runs);
            produced++;
         end
         if (produced == 0) begin
            note_result(KIND_DRAIN_EMPTY, '0, '0, '0, 0);
            produced = 1;
         end
      end else if (r.opcode == OP_CLOSE) begin
         // Flush everything; only entries with a cancel handle report.
         queue_closed = 1'b1;
         while (occupancy > 0) begin
            head_entry = entry_mem[head_slot];
            head_slot = next_slot(head_slot);
            occupancy--;
            if (head_entry.cancel != '0) begin
               note_result(KIND_CANCEL, head_entry.cancel, head_entry.payload, '0, 0);
               produced++;
            end
         end
         note_result(KIND_CLOSE_DONE, '0, '0, '0, 0);
         produced++;
      end
      // The unused opcode gives nothing; otherwise flag the final result.
      if (produced > 0) begin
         last_result = expected_results.pop_back();
         last_result.is_last = 1'b1;
         expected_results.push_back(last_result);
      end
   endtask

   task automatic compare_result(input rsp_type actual);
      rsp_type wanted;
      checked_count++;
      if (expected_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result with none expected: %s", $time, describe(actual));
      end else begin
         wanted = expected_results.pop_front();
         if (actual.result_kind !== wanted.result_kind ||
             actual.out_handle !== wanted.out_handle ||
             actual.out_payload !== wanted.out_payload ||
             actual.out_cost !== wanted.out_cost ||
             actual.is_last !== wanted.is_last ||
             actual.run_count !== wanted.run_count ||
             actual.pending_count !== wanted.pending_count ||
             actual.submitted_total !== wanted.submitted_total ||
             actual.drained_total !== wanted.drained_total) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: result mismatch", $time);
               $display("   expected %s", describe(wanted));
               $display("   actual   %s", describe(actual));
            end
         end
      end
   endtask

   // Results are compared before the same edge's request is predicted, so a
   // stray result can never match a prediction made in the same cycle.
   always @(posedge clock) begin
      if (reset) begin
         head_slot       = 0;
         tail_slot       = 0;
         occupancy       = 0;
         queue_closed    = 1'b0;
         submitted_total = '0;
         drained_total   = '0;
         expected_results.delete();
         outstanding_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            compare_result(rsp_data);
         if (req_valid && req_ready)
            predict_request(req_data);
         outstanding_count <= expected_results.size();
      end
   end

endmodule

// File: tb/cost_budgeted_fifo_queue_unit_test.sv
// Top of the cost-budgeted FIFO command queue testbench.
// Drives requests and result back-pressure into the queue and gives the verdict;
// depends on cbfq_pkg, the queue itself and cbfq_dispatch_checker.
`timescale 1ns / 1ps

module cost_budgeted_fifo_queue_unit_test;
   import cbfq_pkg::*;

   localparam int QUEUE_DEPTH     = QUEUE_DEPTH_DEF;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_TARGET   = 385;
   localparam int DRAIN_OUT_WAIT  = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int mismatch_count;
   int outstanding_count;
   int checked_count;
   int idle_cycles;

   int enqueue_sent;
   int drain_sent;
   int close_sent;
   int unused_sent;

   bit quiet_phase;
   bit hold_off_request;

   cost_budgeted_fifo_queue_unit #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   cbfq_dispatch_checker #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) result_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count),
      .checked_count     (checked_count)
   );

   // Clock with a 2 ns period.
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Request field builders. Fields the opcode ignores carry random junk.
   function automatic req_type scrambled_request();
      req_type r;
      r.opcode          = 2'($urandom_range(0, 3));
      r.callback_handle = $urandom;
      r.payload_word    = $urandom;
      r.entry_cost      = {$urandom, $urandom};
      r.cancel_handle   = $urandom;
      r.run_limit       = 8'($urandom);
      r.cost_budget     = {$urandom, $urandom};
      return r;
   endfunction

   function automatic req_type enqueue_request(input logic [31:0] callback,
                                               input logic [31:0] payload,
                                               input logic [63:0] cost,
                                               input logic [31:0] cancel);
      req_type r;
      r = scrambled_request();
      r.opcode          = OP_ENQUEUE;
      r.callback_handle = callback;
      r.payload_word    = payload;
      r.entry_cost      = cost;
      r.cancel_handle   = cancel;
      return r;
   endfunction

   function automatic req_type drain_request(input logic [7:0] limit, input logic [63:0] budget);
      req_type r;
      r = scrambled_request();
      r.opcode      = OP_DRAIN;
      r.run_limit   = limit;
      r.cost_budget = budget;
      return r;
   endfunction

   function automatic req_type close_request();
      req_type r;
      r = scrambled_request();
      r.opcode = OP_CLOSE;
      return r;
   endfunction

   function automatic req_type unused_request();
      req_type r;
      r = scrambled_request();
      r.opcode = 2'b11;
      return r;
   endfunction

   // Costs lean toward zero and small values so budgets bite often.
   function automatic logic [63:0] pick_cost();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 5)
         return '0;
      else if (sel < 13)
         return 64'($urandom_range(1, 20));
      else if (sel < 14)
         return COST_ALL_ONES;
      else
         return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_budget();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 4)
         return COST_ALL_ONES;
      else if (sel < 6)
         return '0;
      else if (sel < 14)
         return 64'($urandom_range(0, 60));
      else
         return {$urandom, $urandom};
   endfunction

   function automatic req_type random_enqueue();
      logic [31:0] callback;
      logic [31:0] cancel;
      callback = ($urandom_range(0, 99) < 8) ? '0 : $urandom;
      cancel   = ($urandom_range(0, 9) < 3) ? '0 : $urandom;
      return enqueue_request(callback, $urandom, pick_cost(), cancel);
   endfunction

   function automatic req_type random_drain();
      logic [7:0]  limit;
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 3)
         limit = '0;
      else if (sel < 8)
         limit = 8'($urandom_range(1, 5));
      else
         limit = 8'($urandom);
      return drain_request(limit, pick_budget());
   endfunction

   // Offer one request, hold it until accepted, then maybe pause a while.
   task automatic send_request(input req_type r);
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (r.opcode == OP_ENQUEUE)
         enqueue_sent++;
      else if (r.opcode == OP_DRAIN)
         drain_sent++;
      else if (r.opcode == OP_CLOSE)
         close_sent++;
      else
         unused_sent++;
      @(negedge clock);
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin : result_receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 9) == 0)
               stall_left = $urandom_range(1, 12);
         end
      end
   end

   // Watchdog: too long without any handshake ends the run.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      req_type item;
      int      scenario;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_ready        = 1'b0;
      quiet_phase      = 1'b0;
      hold_off_request = 1'b0;
      enqueue_sent     = 0;
      drain_sent       = 0;
      close_sent       = 0;
      unused_sent      = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty drains, null callback, field extremes, budget corners.
      send_request(drain_request(8'd0, COST_ALL_ONES));
      send_request(drain_request(8'd0, 64'd0));
      send_request(enqueue_request(32'd0, 32'h1234_5678, 64'd9, 32'd1));
      send_request(enqueue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, COST_ALL_ONES, 32'hFFFF_FFFF));
      send_request(enqueue_request(32'd1, 32'd0, 64'd0, 32'd0));
      send_request(enqueue_request(32'd2, 32'd5, 64'd5, 32'd7));
      // Item limit of one with an unlimited budget.
      send_request(drain_request(8'd1, COST_ALL_ONES));
      // Zero budget: the zero-cost head runs, the next one does not.
      send_request(drain_request(8'd0, 64'd0));
      // Zero budget against a costly head runs nothing.
      send_request(drain_request(8'd0, 64'd0));
      // The first entry runs even when it alone exceeds the budget.
      send_request(drain_request(8'd0, 64'd1));
      send_request(enqueue_request(32'd3, 32'hAAAA_5555, COST_ALL_ONES, 32'd0));
      send_request(enqueue_request(32'd4, 32'h5555_AAAA, 64'd3, 32'd9));
      send_request(enqueue_request(32'd5, 32'h0F0F_F0F0, 64'd0, 32'd0));
      // A saturated spend blocks every later costly entry.
      send_request(drain_request(8'd0, 64'd10));
      send_request(drain_request(8'd255, 64'd10));
      send_request(enqueue_request(32'd6, 32'd60, 64'd4, 32'd1));
      send_request(enqueue_request(32'd7, 32'd70, 64'd6, 32'd2));
      send_request(enqueue_request(32'd8, 32'd80, 64'd1, 32'd3));
      // Spend lands exactly on the budget, then the next entry is refused.
      send_request(drain_request(8'd0, 64'd10));
      send_request(drain_request(8'd0, 64'hFFFF_FFFF_FFFF_FFFE));
      send_request(unused_request());

      // Back-pressure: results are held off while enqueues keep coming.
      hold_off_request = 1'b1;
      repeat (40) send_request(random_enqueue());
      send_request(drain_request(8'd0, COST_ALL_ONES));

      // Random traffic, mostly enqueue bursts followed by a drain.
      while (enqueue_sent + drain_sent + close_sent < RANDOM_TARGET) begin
         scenario = $urandom_range(0, 19);
         if (scenario < 10) begin
            repeat ($urandom_range(1, 6)) send_request(random_enqueue());
            send_request(random_drain());
         end else if (scenario < 12) begin
            repeat ($urandom_range(30, 36)) send_request(random_enqueue());
            send_request(random_drain());
         end else if (scenario < 17) begin
            send_request(random_drain());
         end else if (scenario < 19) begin
            send_request(random_enqueue());
         end else begin
            send_request(unused_request());
         end
      end

      // Final part without idling: fill up, close with a flush, then poke
      // the closed queue.
      quiet_phase = 1'b1;
      repeat (34) send_request(random_enqueue());
      send_request(close_request());
      send_request(close_request());
      send_request(drain_request(8'd0, COST_ALL_ONES));
      item = random_enqueue();
      item.callback_handle = $urandom | 32'd1;
      send_request(item);
      send_request(enqueue_request(32'd0, $urandom, pick_cost(), $urandom));
      send_request(unused_request());
      repeat (5) send_request(scrambled_request());
      req_valid <= 1'b0;

      // Let every expected result arrive, then keep watching for stray results.
      while (outstanding_count != 0)
         @(posedge clock);
      repeat (DRAIN_OUT_WAIT) @(posedge clock);

      $display("Covered %0d enqueues, %0d drains, %0d closes and %0d unused-opcode requests,",
               enqueue_sent, drain_sent, close_sent, unused_sent);
      $display("with %0d results checked and %0d mismatches.", checked_count, mismatch_count);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
